FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent property checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, masked while reset is low
`define DTFB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dtfb assertion failed");
// next-cycle implication, masked while reset is low
`define DTFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dtfb assertion failed");
`else
`define DTFB_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define DTFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/dtfb_pkg.sv
// ----------------------------------------------------------------------------
// dtfb_pkg
// Shared types and constants of the depth-tested fragment buffer.
// ----------------------------------------------------------------------------
package dtfb_pkg;

    localparam int MAX_COLUMNS_DEF = 512;
    localparam int MAX_ROWS_DEF    = 512;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int BOX_OUT_W = 11;

    // depth 1.0 in unsigned 16.16
    localparam logic [31:0] DEPTH_ONE   = 32'h0001_0000;
    localparam logic [31:0] DEPTH_CLEAR = 32'h0000_0000;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_TAKE  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_BG_RED      = 3'd2,
        REG_BG_GREEN    = 3'd3,
        REG_BG_BLUE     = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_RESPOND
    } state_t;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic               pad;
        logic signed [31:0] loc_z;
        logic signed [31:0] loc_y;
        logic signed [31:0] loc_x;
        logic [5:0]         material_index;
        logic               edge_flag;
        logic [31:0]        depth;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
    } in_item_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [31:0] dirty_total;
        logic [10:0] box_up;
        logic [10:0] box_down;
        logic [10:0] box_right;
        logic [10:0] box_left;
        logic        accepted;
    } out_item_t;

    // stored fragment record: flag byte and location payload
    typedef struct packed {
        logic [31:0] loc_z;
        logic [31:0] loc_y;
        logic [31:0] loc_x;
        logic [5:0]  material_index;
        logic        edge_flag;
        logic        dirty;
    } frag_rec_t;

    // write strobes of the sample store
    typedef struct packed {
        logic we;
        logic we_edge;
    } store_ctl_t;

endpackage

FILE: src/dtfb_store.sv
// ----------------------------------------------------------------------------
// dtfb_store
// Sample store: depth memory with a registered read port, and the fragment
// record memory with a separate strobe for the edge bit.
// ----------------------------------------------------------------------------
module dtfb_store
    import dtfb_pkg::*;
#(
    parameter int DEPTH = MAX_COLUMNS_DEF * MAX_ROWS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_depth,
    input  logic [AW-1:0] wr_addr,
    input  store_ctl_t    wr_ctl,
    input  logic [31:0]   wr_depth,
    input  frag_rec_t     wr_rec
);

    logic [31:0] depth_mem [DEPTH];
    frag_rec_t   rec_mem   [DEPTH];

    always_ff @(posedge aclk) begin
        rd_depth <= depth_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_ctl.we) begin
            depth_mem[wr_addr] <= wr_depth;
        end
    end

    // clear keeps the edge bit, so it is strobed on its own
    always_ff @(posedge aclk) begin
        if (wr_ctl.we) begin
            rec_mem[wr_addr].dirty          <= wr_rec.dirty;
            rec_mem[wr_addr].material_index <= wr_rec.material_index;
            rec_mem[wr_addr].loc_x          <= wr_rec.loc_x;
            rec_mem[wr_addr].loc_y          <= wr_rec.loc_y;
            rec_mem[wr_addr].loc_z          <= wr_rec.loc_z;
        end
        if (wr_ctl.we && wr_ctl.we_edge) begin
            rec_mem[wr_addr].edge_flag <= wr_rec.edge_flag;
        end
    end

endmodule

FILE: src/depth_tested_fragment_buffer.sv
// Flow: a push passes the lookup and respond states, then the output register; take,
//   unused action and empty-grid clear go straight to respond; clear sweeps W*H entries first.
// One item at a time: the next item is taken once the result is loaded, while it
//   waits on m_tready; respond stalls while the output register holds an unread result.
// Reset: synchronous, active low; then a clearing pass over all MAX_COLUMNS*MAX_ROWS
//   entries (262144 at defaults) zeroes the store with s_tready low; APB writes are taken.
// ----------------------------------------------------------------------------
// depth_tested_fragment_buffer
// Per-sample depth buffer with dirty bounding box, saturating push counter,
// grid-wide clear and take-and-reset of the box.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module depth_tested_fragment_buffer
    import dtfb_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // item in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pos_x[15:0] pos_y[31:16] depth[63:32] edge_flag[64] material_index[70:65]
    // loc_x[102:71] loc_y[134:103] loc_z[166:135] zero[167]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    // result out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // accepted[0] box_left[11:1] box_right[22:12] box_down[33:23] box_up[44:34]
    // dirty_total[76:45] zero[79:77]
    output logic [M_TDATA_W-1:0] m_tdata,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int BW    = ((CW > RW) ? CW : RW) + 1;
    localparam int BXW   = (BW > BOX_OUT_W) ? BW : BOX_OUT_W;
    localparam int PW    = CW + RW;
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------------------------------------------------------- registers
    state_t             state_reg, state_next;

    logic [9:0]         grid_width_reg, grid_height_reg;
    logic [30:0]        bg_red_reg, bg_green_reg, bg_blue_reg;

    action_t            act_reg;
    logic               pass_reg;
    logic [CW-1:0]      px_reg;
    logic [RW-1:0]      py_reg;
    logic [31:0]        depth_reg;
    logic               edge_reg;
    logic [5:0]         mat_reg;
    logic [31:0]        lx_reg, ly_reg, lz_reg;
    logic [AW-1:0]      addr_reg;

    logic [AW-1:0]      sweep_addr_reg, sweep_last_reg;

    logic signed [BW-1:0] box_l_reg, box_r_reg, box_d_reg, box_u_reg;
    logic signed [BW-1:0] box_l_next, box_r_next, box_d_next, box_u_next;
    logic [31:0]        cnt_reg, cnt_next;

    out_item_t          out_reg, out_next;
    logic               m_valid_reg;

    // ---------------------------------------------------------------- store
    logic [31:0]        rd_depth;
    logic [AW-1:0]      wr_addr;
    store_ctl_t         wr_ctl;
    logic [31:0]        wr_depth;
    frag_rec_t          wr_rec;

    dtfb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk     (aclk),
        .rd_addr  (addr_reg),
        .rd_depth (rd_depth),
        .wr_addr  (wr_addr),
        .wr_ctl   (wr_ctl),
        .wr_depth (wr_depth),
        .wr_rec   (wr_rec)
    );

    // ---------------------------------------------------------------- config
    logic     cfg_we;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= 10'd1;
            grid_height_reg <= 10'd1;
            bg_red_reg      <= '0;
            bg_green_reg    <= '0;
            bg_blue_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[9:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[9:0];
                REG_BG_RED:      bg_red_reg      <= pwdata[30:0];
                REG_BG_GREEN:    bg_green_reg    <= pwdata[30:0];
                REG_BG_BLUE:     bg_blue_reg     <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_reg);
            REG_BG_RED:      prdata = PDATA_W'(bg_red_reg);
            REG_BG_GREEN:    prdata = PDATA_W'(bg_green_reg);
            REG_BG_BLUE:     prdata = PDATA_W'(bg_blue_reg);
            default:         prdata = '0;
        endcase
    end

    // clamp the grid to the store size
    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;

    assign eff_w = (32'(grid_width_reg) > 32'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS)
                                                            : CW'(grid_width_reg);
    assign eff_h = (32'(grid_height_reg) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS)
                                                          : RW'(grid_height_reg);

    // ---------------------------------------------------------------- accept
    in_item_t in_item;
    action_t  in_act;
    logic     s_accept;
    logic     in_x_ok, in_y_ok, in_z_ok;
    logic [PW-1:0] in_index, clr_limit;
    logic     clr_empty;

    assign in_item  = in_item_t'(s_tdata);
    assign in_act   = action_t'(s_tuser[1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // bounds and near-plane test at acceptance; the store index is y*W + x
    assign in_x_ok = !in_item.pos_x[15] && ({1'b0, in_item.pos_x[14:0]} < 16'(eff_w));
    assign in_y_ok = !in_item.pos_y[15] && ({1'b0, in_item.pos_y[14:0]} < 16'(eff_h));
    assign in_z_ok = in_item.depth > DEPTH_ONE;
    assign in_index = PW'(in_item.pos_y[RW-1:0]) * PW'(eff_w) + PW'(in_item.pos_x[CW-1:0]);

    assign clr_limit = PW'(eff_w) * PW'(eff_h);
    assign clr_empty = (eff_w == '0) || (eff_h == '0);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg   <= in_act;
            pass_reg  <= in_x_ok && in_y_ok && in_z_ok;
            px_reg    <= in_item.pos_x[CW-1:0];
            py_reg    <= in_item.pos_y[RW-1:0];
            depth_reg <= in_item.depth;
            edge_reg  <= in_item.edge_flag;
            mat_reg   <= in_item.material_index;
            lx_reg    <= in_item.loc_x;
            ly_reg    <= in_item.loc_y;
            lz_reg    <= in_item.loc_z;
            addr_reg  <= AW'(in_index);
        end
    end

    // ---------------------------------------------------------------- sweep
    logic sweep_done;
    logic init_done;

    assign sweep_done = (sweep_addr_reg == sweep_last_reg);
    assign init_done  = (sweep_addr_reg == AW'(DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_addr_reg <= '0;
            sweep_last_reg <= '0;
        end else if (s_accept && in_act == ACT_CLEAR) begin
            sweep_addr_reg <= '0;
            sweep_last_reg <= AW'(clr_limit - PW'(1));
        end else if (state_reg == ST_INIT || state_reg == ST_SWEEP) begin
            sweep_addr_reg <= sweep_addr_reg + AW'(1);
        end
    end

    // ---------------------------------------------------------------- decide
    logic out_free;
    logic win;

    assign out_free = !m_valid_reg || m_tready;
    // nearer than what the store holds, read back during lookup
    assign win      = (act_reg == ACT_PUSH) && pass_reg && (depth_reg > rd_depth);

    function automatic logic [BOX_OUT_W-1:0] box_bits(input logic signed [BW-1:0] v);
        logic signed [BXW-1:0] e;
        e = BXW'(v);
        return e[BOX_OUT_W-1:0];
    endfunction

    logic signed [BW-1:0] px_s, py_s, empty_l, empty_d;

    assign px_s    = $signed(BW'(px_reg));
    assign py_s    = $signed(BW'(py_reg));
    assign empty_l = $signed(BW'(eff_w));
    assign empty_d = $signed(BW'(eff_h));

    always_comb begin
        box_l_next = box_l_reg;
        box_r_next = box_r_reg;
        box_d_next = box_d_reg;
        box_u_next = box_u_reg;
        cnt_next   = cnt_reg;
        case (act_reg)
            ACT_PUSH: begin
                if (win) begin
                    if (px_s < box_l_reg) box_l_next = px_s;
                    if (px_s > box_r_reg) box_r_next = px_s;
                    if (py_s < box_d_reg) box_d_next = py_s;
                    if (py_s > box_u_reg) box_u_next = py_s;
                    if (cnt_reg != '1) cnt_next = cnt_reg + 32'd1;
                end
            end
            ACT_CLEAR, ACT_TAKE: begin
                box_l_next = empty_l;
                box_r_next = '1;
                box_d_next = empty_d;
                box_u_next = '1;
                cnt_next   = '0;
            end
            default: ;
        endcase
    end

    // take reports the box before emptying it; the rest report it after
    always_comb begin
        out_next     = '0;
        out_next.accepted = win;
        if (act_reg == ACT_TAKE) begin
            out_next.box_left    = box_bits(box_l_reg);
            out_next.box_right   = box_bits(box_r_reg);
            out_next.box_down    = box_bits(box_d_reg);
            out_next.box_up      = box_bits(box_u_reg);
            out_next.dirty_total = cnt_reg;
        end else begin
            out_next.box_left    = box_bits(box_l_next);
            out_next.box_right   = box_bits(box_r_next);
            out_next.box_down    = box_bits(box_d_next);
            out_next.box_up      = box_bits(box_u_next);
            out_next.dirty_total = cnt_next;
        end
    end

    logic respond_fire;
    assign respond_fire = (state_reg == ST_RESPOND) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_l_reg <= BW'(1);
            box_r_reg <= '1;
            box_d_reg <= BW'(1);
            box_u_reg <= '1;
            cnt_reg   <= '0;
        end else if (respond_fire) begin
            box_l_reg <= box_l_next;
            box_r_reg <= box_r_next;
            box_d_reg <= box_d_next;
            box_u_reg <= box_u_next;
            cnt_reg   <= cnt_next;
        end
    end

    // output register parts the result side from the item side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (respond_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (respond_fire) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

    // ---------------------------------------------------------------- control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (init_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_act)
                        ACT_PUSH:  state_next = ST_LOOKUP;
                        ACT_CLEAR: state_next = clr_empty ? ST_RESPOND : ST_SWEEP;
                        default:   state_next = ST_RESPOND;
                    endcase
                end
            end
            ST_LOOKUP: state_next = ST_RESPOND;
            ST_SWEEP: begin
                if (sweep_done) state_next = ST_RESPOND;
            end
            ST_RESPOND: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // store writes: reset pass zeroes all, clear keeps the edge bit, push writes all
    always_comb begin
        wr_ctl   = '0;
        wr_addr  = addr_reg;
        wr_depth = depth_reg;
        wr_rec   = '0;
        case (state_reg)
            ST_INIT: begin
                wr_ctl.we      = 1'b1;
                wr_ctl.we_edge = 1'b1;
                wr_addr        = sweep_addr_reg;
                wr_depth       = DEPTH_CLEAR;
            end
            ST_SWEEP: begin
                wr_ctl.we    = 1'b1;
                wr_addr      = sweep_addr_reg;
                wr_depth     = DEPTH_CLEAR;
                wr_rec.loc_x = 32'(bg_red_reg);
                wr_rec.loc_y = 32'(bg_green_reg);
                wr_rec.loc_z = 32'(bg_blue_reg);
            end
            ST_RESPOND: begin
                wr_ctl.we             = out_free && win;
                wr_ctl.we_edge        = 1'b1;
                wr_rec.dirty          = 1'b1;
                wr_rec.edge_flag      = edge_reg;
                wr_rec.material_index = mat_reg;
                wr_rec.loc_x          = lx_reg;
                wr_rec.loc_y          = ly_reg;
                wr_rec.loc_z          = lz_reg;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- checks
    `DTFB_ASSERT_IMPL(a_count_box, aclk, aresetn, cnt_reg != 32'd0, box_r_reg >= 0 && box_l_reg <= box_r_reg)
    `DTFB_ASSERT_IMPL(a_sweep_bound, aclk, aresetn, state_reg == ST_SWEEP, sweep_addr_reg <= sweep_last_reg)
    `DTFB_ASSERT_IMPL(a_push_write, aclk, aresetn, wr_ctl.we && state_reg == ST_RESPOND, act_reg == ACT_PUSH && out_free)
    `DTFB_ASSERT_NEXT(a_result_load, aclk, aresetn, respond_fire, m_tvalid)

endmodule
